// ----- src/x86lsr_pkg.sv -----
// ----------------------------------------------------------------------------
// x86lsr_pkg
// Shared types, codes and helpers of the x86 logic/shift/rotate unit.
// ----------------------------------------------------------------------------
package x86lsr_pkg;

  typedef enum logic [3:0] {
    OP_AND  = 4'd0,
    OP_OR   = 4'd1,
    OP_XOR  = 4'd2,
    OP_ROL  = 4'd3,
    OP_ROR  = 4'd4,
    OP_SHL  = 4'd5,
    OP_SHR  = 4'd6,
    OP_SAR  = 4'd7,
    OP_RCL  = 4'd8,
    OP_RCR  = 4'd9,
    OP_SHLD = 4'd10,
    OP_SHRD = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2
  } sz_t;

  localparam int unsigned DataW  = 32;
  localparam int unsigned VecW   = 66;
  localparam int unsigned AmtW   = 6;

  typedef struct packed {
    logic [3:0] op;
    sz_t        sz;
    logic       act;
    logic       c_le_w;
    logic       ci;
    logic       dtop;
  } ctrl_t;

  typedef struct packed {
    logic cf;
    logic of;
    logic sf;
    logic zf;
    logic pf;
    logic cf_wr;
    logic of_wr;
    logic szp_wr;
  } flags_t;

  function automatic logic [DataW-1:0] size_mask(sz_t sz);
    logic [DataW-1:0] m;
    unique case (sz)
      SZ_8:    m = 32'h0000_00FF;
      SZ_16:   m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [AmtW-1:0] size_width(sz_t sz);
    logic [AmtW-1:0] w;
    unique case (sz)
      SZ_8:    w = 6'd8;
      SZ_16:   w = 6'd16;
      default: w = 6'd32;
    endcase
    return w;
  endfunction

  function automatic logic top_bit(logic [DataW-1:0] x, sz_t sz);
    logic b;
    unique case (sz)
      SZ_8:    b = x[7];
      SZ_16:   b = x[15];
      default: b = x[31];
    endcase
    return b;
  endfunction

  function automatic logic second_bit(logic [DataW-1:0] x, sz_t sz);
    logic b;
    unique case (sz)
      SZ_8:    b = x[6];
      SZ_16:   b = x[14];
      default: b = x[30];
    endcase
    return b;
  endfunction

endpackage

// ----- src/x86lsr_in_if.sv -----
// ----------------------------------------------------------------------------
// x86lsr_in_if
// Operation channel: valid/ready handshake with operands and opcode.
// ----------------------------------------------------------------------------
interface x86lsr_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [1:0]  size_sel;
  logic [31:0] dest;
  logic [31:0] src;
  logic [7:0]  count;
  logic        carry_in;

  modport source (
    output valid, mode, size_sel, dest, src, count, carry_in,
    input  ready
  );

  modport sink (
    input  valid, mode, size_sel, dest, src, count, carry_in,
    output ready
  );
endinterface

// ----- src/x86lsr_out_if.sv -----
// ----------------------------------------------------------------------------
// x86lsr_out_if
// Result channel: valid/ready handshake with result, flags and enables.
// ----------------------------------------------------------------------------
interface x86lsr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        cf;
  logic        of;
  logic        sf;
  logic        zf;
  logic        pf;
  logic        cf_written;
  logic        of_written;
  logic        szp_written;

  modport source (
    output valid, result, cf, of, sf, zf, pf, cf_written, of_written, szp_written,
    input  ready
  );

  modport sink (
    input  valid, result, cf, of, sf, zf, pf, cf_written, of_written, szp_written,
    output ready
  );
endinterface

// ----- src/x86lsr_flag_gen.sv -----
// ----------------------------------------------------------------------------
// x86lsr_flag_gen
// Flag values and write enables from the shifted result and op context.
// ----------------------------------------------------------------------------
module x86lsr_flag_gen (
  input  x86lsr_pkg::ctrl_t  ctrl,
  input  logic [31:0]        res,
  input  logic               shift_cf,
  output x86lsr_pkg::flags_t flags
);
  import x86lsr_pkg::*;

  logic top;
  logic sec;
  logic cf;
  logic of;
  logic wc;
  logic wo;
  logic wszp;

  always_comb begin
    top  = top_bit(res, ctrl.sz);
    sec  = second_bit(res, ctrl.sz);
    cf   = 1'b0;
    of   = 1'b0;
    wc   = 1'b0;
    wo   = 1'b0;
    wszp = 1'b0;
    if (ctrl.act) begin
      unique case (ctrl.op)
        OP_AND, OP_OR, OP_XOR: begin
          wc   = 1'b1;
          wo   = 1'b1;
          wszp = 1'b1;
        end
        OP_ROL: begin
          cf = res[0];
          of = top ^ res[0];
          wc = 1'b1;
          wo = 1'b1;
        end
        OP_ROR: begin
          cf = top;
          of = top ^ sec;
          wc = 1'b1;
          wo = 1'b1;
        end
        OP_SHL: begin
          cf   = shift_cf;
          wc   = ctrl.c_le_w;
          of   = top ^ (ctrl.c_le_w ? shift_cf : ctrl.ci);
          wo   = 1'b1;
          wszp = 1'b1;
        end
        OP_SHR: begin
          cf   = shift_cf;
          of   = ctrl.dtop;
          wc   = ctrl.c_le_w;
          wo   = ctrl.c_le_w;
          wszp = 1'b1;
        end
        OP_SAR: begin
          cf   = shift_cf;
          wc   = 1'b1;
          wo   = 1'b1;
          wszp = 1'b1;
        end
        OP_RCL: begin
          cf = shift_cf;
          of = top ^ shift_cf;
          wc = 1'b1;
          wo = 1'b1;
        end
        OP_RCR: begin
          cf = shift_cf;
          of = top ^ sec;
          wc = 1'b1;
          wo = 1'b1;
        end
        OP_SHLD: begin
          cf   = shift_cf;
          of   = shift_cf ^ top;
          wc   = 1'b1;
          wo   = 1'b1;
          wszp = 1'b1;
        end
        OP_SHRD: begin
          cf   = shift_cf;
          of   = top ^ ctrl.dtop;
          wc   = 1'b1;
          wo   = 1'b1;
          wszp = 1'b1;
        end
        default: begin
          wc = 1'b0;
        end
      endcase
    end
    flags.cf     = wc & cf;
    flags.of     = wo & of;
    flags.sf     = wszp & top;
    flags.zf     = wszp & (res == 32'h0);
    flags.pf     = wszp & ~(^res[7:0]);
    flags.cf_wr  = wc;
    flags.of_wr  = wo;
    flags.szp_wr = wszp;
  end

endmodule

// ----- src/x86_logic_shift_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// x86_logic_shift_rotate_unit: x86 logic, shift and rotate execution unit.
// Results are registered through the decode, 66-bit barrel shift and flag stages;
// one transaction per cycle sustained while the result channel is ready.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module x86_logic_shift_rotate_unit (
  input  logic             clk,
  input  logic             rst_n,
  x86lsr_in_if.sink        in_ch,
  x86lsr_out_if.source     out_ch
);
  import x86lsr_pkg::*;

  // stage handshake
  logic s1_adv;
  logic s2_adv;
  logic out_adv;

  // decode
  sz_t              sz;
  logic [31:0]      m;
  logic [31:0]      d_m;
  logic [31:0]      s_m;
  logic [4:0]       c;
  logic [4:0]       r;
  logic [4:0]       rr;
  logic [5:0]       w6;
  logic [31:0]      rep;
  logic [31:0]      sx;
  logic [VecW-1:0]  ring;
  logic             neg;
  logic             is_log;
  logic             is_sh;

  ctrl_t            s1_ctrl_nxt;
  logic [VecW-1:0]  s1_vec_nxt;
  logic [AmtW-1:0]  s1_amt_nxt;
  logic             s1_hi_nxt;

  logic             s1_v_r;
  ctrl_t            s1_ctrl_r;
  logic [VecW-1:0]  s1_vec_r;
  logic [AmtW-1:0]  s1_amt_r;
  logic             s1_hi_r;

  // shift
  logic [VecW-1:0]  sh;
  logic [31:0]      s2_res_nxt;
  logic             s2_cf_nxt;

  logic             s2_v_r;
  ctrl_t            s2_ctrl_r;
  logic [31:0]      s2_res_r;
  logic             s2_cf_r;

  // flags / output
  flags_t           out_flags_nxt;
  logic             out_v_r;
  logic [31:0]      out_res_r;
  flags_t           out_flags_r;

  assign out_adv     = !out_v_r || out_ch.ready;
  assign s2_adv      = !s2_v_r || out_adv;
  assign s1_adv      = !s1_v_r || s2_adv;
  assign in_ch.ready = s1_adv;

  // ---------------- stage 1: decode and shifter operand ----------------
  always_comb begin
    unique case (in_ch.size_sel)
      SZ_8:    sz = SZ_8;
      SZ_16:   sz = SZ_16;
      default: sz = SZ_32;
    endcase
    if ((in_ch.mode == OP_SHLD || in_ch.mode == OP_SHRD) && sz == SZ_8) begin
      sz = SZ_16;
    end
    m      = size_mask(sz);
    w6     = size_width(sz);
    d_m    = in_ch.dest & m;
    s_m    = in_ch.src & m;
    c      = in_ch.count[4:0];
    r      = c & 5'(w6 - 6'd1);
    neg    = top_bit(d_m, sz);
    sx     = neg ? (d_m | ~m) : d_m;
    is_log = in_ch.mode <= OP_XOR;
    is_sh  = in_ch.mode >= OP_ROL && in_ch.mode <= OP_SHRD;

    unique case (sz)
      SZ_8: begin
        rep  = {4{d_m[7:0]}};
        ring = {48'b0, in_ch.carry_in, d_m[7:0], in_ch.carry_in, d_m[7:0]};
        if (c >= 5'd27) begin
          rr = c - 5'd27;
        end else if (c >= 5'd18) begin
          rr = c - 5'd18;
        end else if (c >= 5'd9) begin
          rr = c - 5'd9;
        end else begin
          rr = c;
        end
      end
      SZ_16: begin
        rep  = {2{d_m[15:0]}};
        ring = {32'b0, in_ch.carry_in, d_m[15:0], in_ch.carry_in, d_m[15:0]};
        rr   = (c >= 5'd17) ? (c - 5'd17) : c;
      end
      default: begin
        rep  = d_m;
        ring = {in_ch.carry_in, d_m, in_ch.carry_in, d_m};
        rr   = c;
      end
    endcase

    s1_ctrl_nxt.op     = in_ch.mode;
    s1_ctrl_nxt.sz     = sz;
    s1_ctrl_nxt.act    = is_log || (is_sh && (c != 5'd0));
    s1_ctrl_nxt.c_le_w = {1'b0, c} <= w6;
    s1_ctrl_nxt.ci     = in_ch.carry_in;
    s1_ctrl_nxt.dtop   = neg;

    s1_vec_nxt = {34'b0, d_m};
    s1_amt_nxt = '0;
    s1_hi_nxt  = 1'b0;
    if (s1_ctrl_nxt.act) begin
      unique case (in_ch.mode)
        OP_AND: s1_vec_nxt = {34'b0, d_m & s_m};
        OP_OR:  s1_vec_nxt = {34'b0, d_m | s_m};
        OP_XOR: s1_vec_nxt = {34'b0, d_m ^ s_m};
        OP_ROL: begin
          s1_vec_nxt = {2'b0, rep, rep};
          s1_amt_nxt = 6'd32 - {1'b0, r};
        end
        OP_ROR: begin
          s1_vec_nxt = {2'b0, rep, rep};
          s1_amt_nxt = {1'b0, r};
        end
        OP_SHL: begin
          s1_vec_nxt = {2'b0, d_m, 32'b0};
          s1_amt_nxt = 6'd32 - {1'b0, c};
        end
        OP_SHR: begin
          s1_vec_nxt = {33'b0, d_m, 1'b0};
          s1_amt_nxt = {1'b0, c};
          s1_hi_nxt  = 1'b1;
        end
        OP_SAR: begin
          s1_vec_nxt = {{33{neg}}, sx, 1'b0};
          s1_amt_nxt = {1'b0, c};
          s1_hi_nxt  = 1'b1;
        end
        OP_RCL: begin
          s1_vec_nxt = ring;
          s1_amt_nxt = w6 + 6'd1 - {1'b0, rr};
        end
        OP_RCR: begin
          s1_vec_nxt = ring;
          s1_amt_nxt = {1'b0, rr};
        end
        OP_SHLD: begin
          if (sz == SZ_16) begin
            s1_vec_nxt = {18'b0, d_m[15:0], s_m[15:0], d_m[15:0]};
          end else begin
            s1_vec_nxt = {2'b0, d_m, s_m};
          end
          s1_amt_nxt = 6'd32 - {1'b0, c};
        end
        OP_SHRD: begin
          if (sz == SZ_16) begin
            s1_vec_nxt = {17'b0, d_m[15:0], s_m[15:0], d_m[15:0], 1'b0};
          end else begin
            s1_vec_nxt = {1'b0, s_m, d_m, 1'b0};
          end
          s1_amt_nxt = {1'b0, c};
          s1_hi_nxt  = 1'b1;
        end
        default: begin
          s1_vec_nxt = {34'b0, d_m};
        end
      endcase
    end
  end

  // ---------------- stage 2: barrel shift ----------------
  always_comb begin
    sh         = s1_vec_r >> s1_amt_r;
    s2_res_nxt = (s1_hi_r ? sh[32:1] : sh[31:0]) & size_mask(s1_ctrl_r.sz);
    if (s1_hi_r) begin
      s2_cf_nxt = sh[0];
    end else begin
      unique case (s1_ctrl_r.sz)
        SZ_8:    s2_cf_nxt = sh[8];
        SZ_16:   s2_cf_nxt = sh[16];
        default: s2_cf_nxt = sh[32];
      endcase
    end
  end

  // ---------------- stage 3: flags ----------------
  x86lsr_flag_gen u_flag_gen (
    .ctrl     (s2_ctrl_r),
    .res      (s2_res_r),
    .shift_cf (s2_cf_r),
    .flags    (out_flags_nxt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_ctrl_r <= s1_ctrl_nxt;
      s1_vec_r  <= s1_vec_nxt;
      s1_amt_r  <= s1_amt_nxt;
      s1_hi_r   <= s1_hi_nxt;
    end
    if (s2_adv && s1_v_r) begin
      s2_ctrl_r <= s1_ctrl_r;
      s2_res_r  <= s2_res_nxt;
      s2_cf_r   <= s2_cf_nxt;
    end
    if (out_adv && s2_v_r) begin
      out_res_r   <= s2_res_r;
      out_flags_r <= out_flags_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.result      = out_res_r;
  assign out_ch.cf          = out_flags_r.cf;
  assign out_ch.of          = out_flags_r.of;
  assign out_ch.sf          = out_flags_r.sf;
  assign out_ch.zf          = out_flags_r.zf;
  assign out_ch.pf          = out_flags_r.pf;
  assign out_ch.cf_written  = out_flags_r.cf_wr;
  assign out_ch.of_written  = out_flags_r.of_wr;
  assign out_ch.szp_written = out_flags_r.szp_wr;

endmodule
